// File: hw/rtl/goal_reach_heading_controller_macros.svh
// Assertion helpers for the heading controller.
`ifndef GOAL_REACH_HEADING_CONTROLLER_MACROS_SVH
`define GOAL_REACH_HEADING_CONTROLLER_MACROS_SVH

// same-cycle implication
`define GRHC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define GRHC_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// File: hw/rtl/grhc_pkg.sv
// ----------------------------------------------------------------------------
// grhc_pkg
// Types and constants shared by the heading controller and its CORDIC.
// ----------------------------------------------------------------------------
`default_nettype none
package grhc_pkg;

  localparam int CW    = 36;  // CORDIC x/y width
  localparam int ZW    = 24;  // CORDIC angle width, Q.20
  localparam int ITERS = 16;

  localparam logic signed [ZW-1:0] PI_Q20      = 24'sd3294199;
  localparam logic signed [16:0]   PI_Q12      = 17'sd12868;
  localparam logic signed [16:0]   TWO_PI_Q12  = 17'sd25736;
  localparam logic signed [16:0]   I_LIMIT_Q12 = 17'sd410;
  localparam logic [15:0]          INV_GAIN_Q16 = 16'd39797;

  typedef enum logic [2:0] {
    S_IDLE, S_BSTART, S_BWAIT, S_DSTART, S_DWAIT, S_MUL, S_SUM, S_OUT
  } state_t;

  typedef enum logic [1:0] {
    MODE_DRIVE = 2'd0, MODE_WAIT = 2'd1, MODE_ALIGN = 2'd2, MODE_DONE = 2'd3
  } mode_t;

  typedef enum logic [2:0] {
    CFG_MAX_LIN, CFG_MAX_ANG, CFG_HEAD_GAIN, CFG_INT_GAIN,
    CFG_GOAL_RADIUS, CFG_TURN_ANGLE, CFG_ALIGN_TOL, CFG_WAIT_TICKS
  } cfg_idx_t;

  typedef struct packed {
    logic                 busy;
    logic                 done;
    logic signed [CW-1:0] mag;
    logic signed [ZW-1:0] ang;
  } cordic_res_t;

  function automatic logic [19:0] atan_q20(input logic [3:0] i);
    logic [19:0] r;
    case (i)
      4'd0:    r = 20'd823550;
      4'd1:    r = 20'd486170;
      4'd2:    r = 20'd256879;
      4'd3:    r = 20'd130396;
      4'd4:    r = 20'd65451;
      4'd5:    r = 20'd32757;
      4'd6:    r = 20'd16383;
      4'd7:    r = 20'd8192;
      4'd8:    r = 20'd4096;
      4'd9:    r = 20'd2048;
      4'd10:   r = 20'd1024;
      4'd11:   r = 20'd512;
      4'd12:   r = 20'd256;
      4'd13:   r = 20'd128;
      4'd14:   r = 20'd64;
      default: r = 20'd32;
    endcase
    return r;
  endfunction

  // symmetric clamp to +-lim
  function automatic logic signed [15:0] sat_ang(input logic signed [23:0] v,
                                                 input logic [14:0] lim);
    logic signed [23:0] l;
    logic signed [15:0] r;
    l = $signed({9'b0, lim});
    if (v > l) r = $signed({1'b0, lim});
    else if (v < -l) r = -$signed({1'b0, lim});
    else r = v[15:0];
    return r;
  endfunction

endpackage
`default_nettype wire

// File: hw/rtl/grhc_cordic.sv
// ----------------------------------------------------------------------------
// grhc_cordic
// Iterative vectoring CORDIC, one micro-rotation per cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module grhc_cordic (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          start,
  input  wire logic signed [grhc_pkg::CW-1:0] x_in,
  input  wire logic signed [grhc_pkg::CW-1:0] y_in,
  output grhc_pkg::cordic_res_t               res
);
  import grhc_pkg::*;

  logic signed [CW-1:0] x, y, x_next, y_next, xs, ys;
  logic signed [ZW-1:0] z, z_next, a;
  logic [3:0]           it;
  logic                 busy, done;

  always_comb begin
    xs = x >>> it;
    ys = y >>> it;
    a  = $signed({{(ZW-20){1'b0}}, atan_q20(it)});
    if (y > 0) begin
      x_next = x + ys;
      y_next = y - xs;
      z_next = z + a;
    end else begin
      x_next = x - ys;
      y_next = y + xs;
      z_next = z - a;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      it   <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        x    <= x_in;
        y    <= y_in;
        z    <= '0;
        it   <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        x  <= x_next;
        y  <= y_next;
        z  <= z_next;
        it <= it + 4'd1;
        if (it == 4'(ITERS-1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign res = '{busy: busy, done: done, mag: x, ang: z};

endmodule
`default_nettype wire

// File: hw/rtl/goal_reach_heading_controller.sv
// A go-to-goal controller with final yaw alignment. Each tick beat (tuser 0)
// yields one command beat once a path beat (tuser 1) has been seen; path beats
// and ticks before any path give no output. After a tick is accepted, one
// shared CORDIC runs 16 rotations for the target bearing and then 16 for the
// goal distance (a start state, then a wait state until done, for each pass),
// followed by a multiply, a sum and an output stage. Input ready returns once
// the result is loaded into the output register. One tick is processed at a
// time; the result sits in an output register, so the next tick can be taken
// while it waits, and that tick then holds in the output stage until the
// register is read.
// Config writes must only happen while the block is idle.
// ----------------------------------------------------------------------------
// goal_reach_heading_controller
// Drive / stop-wait / align / done mode machine with saturated commands.
// ----------------------------------------------------------------------------
`default_nettype none
module goal_reach_heading_controller (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [30:0]  cfg_data,
  input  wire logic         s_tvalid,
  output      logic         s_tready,
  // target_dx, target_dy, robot_x, robot_y, robot_heading, goal_x, goal_y,
  // goal_heading
  input  wire logic [223:0] s_tdata,
  // kind
  input  wire logic         s_tuser,
  output      logic         m_tvalid,
  input  wire logic         m_tready,
  // linear_cmd, angular_cmd, mode
  output      logic [55:0]  m_tdata
);
  import grhc_pkg::*;

  // config
  logic [30:0] max_lin, goal_radius;
  logic [14:0] max_ang, head_gain, int_gain;
  logic [13:0] turn_angle, align_tol;
  logic [15:0] wait_ticks;

  always_ff @(posedge clk) begin
    if (rst) begin
      max_lin     <= 31'd9830;
      max_ang     <= 15'd4915;
      head_gain   <= 15'd6144;
      int_gain    <= 15'd4096;
      goal_radius <= 31'd9830;
      turn_angle  <= 14'd1024;
      align_tol   <= 14'd205;
      wait_ticks  <= 16'd20;
    end else if (cfg_we) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_MAX_LIN:     max_lin     <= cfg_data;
        CFG_MAX_ANG:     max_ang     <= cfg_data[14:0];
        CFG_HEAD_GAIN:   head_gain   <= cfg_data[14:0];
        CFG_INT_GAIN:    int_gain    <= cfg_data[14:0];
        CFG_GOAL_RADIUS: goal_radius <= cfg_data;
        CFG_TURN_ANGLE:  turn_angle  <= cfg_data[13:0];
        CFG_ALIGN_TOL:   align_tol   <= cfg_data[13:0];
        CFG_WAIT_TICKS:  wait_ticks  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // input field views
  logic signed [31:0] in_tdx, in_tdy, in_rx, in_ry, in_gx, in_gy;
  logic signed [14:0] in_ryaw, in_gyaw;
  assign in_tdx  = s_tdata[31:0];
  assign in_tdy  = s_tdata[63:32];
  assign in_rx   = s_tdata[95:64];
  assign in_ry   = s_tdata[127:96];
  assign in_ryaw = s_tdata[142:128];
  assign in_gx   = s_tdata[174:143];
  assign in_gy   = s_tdata[206:175];
  assign in_gyaw = s_tdata[221:207];

  state_t state, state_next;
  mode_t  mode, mode_next;
  logic [15:0] wc, wc_next;
  logic        path_loaded;

  logic accept, tick_go, out_free, out_load;
  assign accept   = s_tvalid && s_tready;
  assign tick_go  = accept && !s_tuser && path_loaded;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = (state == S_OUT) && out_free;

  // latched operands
  logic signed [31:0] tdx, tdy;
  logic signed [32:0] gdx, gdy;
  logic signed [16:0] yerr;

  always_ff @(posedge clk) begin
    if (tick_go) begin
      tdx  <= in_tdx;
      tdy  <= in_tdy;
      gdx  <= $signed({in_gx[31], in_gx}) - $signed({in_rx[31], in_rx});
      gdy  <= $signed({in_gy[31], in_gy}) - $signed({in_ry[31], in_ry});
      yerr <= $signed({{2{in_gyaw[14]}}, in_gyaw}) - $signed({{2{in_ryaw[14]}}, in_ryaw});
    end
  end

  // shared CORDIC: bearing pass with the half plane folded, then distance pass
  logic                 cstart, bneg;
  logic signed [CW-1:0] cx, cy, etdx, etdy, egdx, egdy;
  cordic_res_t          cres;

  assign bneg = tdx[31];
  assign etdx = CW'(tdx);
  assign etdy = CW'(tdy);
  assign egdx = CW'(gdx);
  assign egdy = CW'(gdy);

  always_comb begin
    if (state == S_BSTART) begin
      cx = bneg ? -etdx : etdx;
      cy = bneg ? -etdy : etdy;
    end else begin
      cx = egdx[CW-1] ? -egdx : egdx;
      cy = egdy[CW-1] ? -egdy : egdy;
    end
  end

  grhc_cordic u_cordic (
    .clk   (clk),
    .rst   (rst),
    .start (cstart),
    .x_in  (cx),
    .y_in  (cy),
    .res   (cres)
  );

  // bearing round: Q.20 -> Q3.12, half up
  logic signed [ZW-1:0] zsum, zrnd;
  always_comb begin
    zsum = cres.ang;
    if (bneg) zsum = tdy[31] ? cres.ang - PI_Q20 : cres.ang + PI_Q20;
    zrnd = (zsum + 24'sd128) >>> 8;
  end

  logic signed [15:0]   bearing;
  logic signed [CW-1:0] mag;
  logic signed [52:0]   gprod;
  logic signed [31:0]   pb;
  logic signed [32:0]   pe, pi_prod;
  logic signed [16:0]   e, e_w, integ;
  logic signed [36:0]   gdist;
  logic signed [20:0]   ang_d;
  logic signed [21:0]   ang_a;

  // yaw error wrap by a single 2*pi step, integral clamp
  always_comb begin
    e_w = yerr;
    if (yerr > PI_Q12) e_w = yerr - TWO_PI_Q12;
    else if (yerr < -PI_Q12) e_w = yerr + TWO_PI_Q12;
    integ = e_w;
    if (e_w > I_LIMIT_Q12) integ = I_LIMIT_Q12;
    else if (e_w < -I_LIMIT_Q12) integ = -I_LIMIT_Q12;
  end

  logic signed [52:0] gs;
  logic signed [32:0] sd;
  logic signed [33:0] sa;
  assign gs = gprod + 53'sd32768;
  assign sd = {pb[31], pb} + 33'sd2048;
  assign sa = {pe[32], pe} + {pi_prod[32], pi_prod} + 34'sd2048;

  always_ff @(posedge clk) begin
    if (state == S_BWAIT && cres.done)
      bearing <= (tdx == 32'sd0 && tdy == 32'sd0) ? 16'sd0 : zrnd[15:0];
    if (state == S_DWAIT && cres.done)
      mag <= cres.mag;
    if (state == S_MUL) begin
      gprod   <= mag * $signed({1'b0, INV_GAIN_Q16});
      pb      <= bearing * $signed({1'b0, head_gain});
      pe      <= e_w * $signed({1'b0, head_gain});
      pi_prod <= integ * $signed({1'b0, int_gain});
      e       <= e_w;
    end
    if (state == S_SUM) begin
      gdist <= gs[52:16];
      ang_d <= sd[32:12];
      ang_a <= sa[33:12];
    end
  end

  // next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE:   if (tick_go) state_next = S_BSTART;
      S_BSTART: state_next = S_BWAIT;
      S_BWAIT:  if (cres.done) state_next = S_DSTART;
      S_DSTART: state_next = S_DWAIT;
      S_DWAIT:  if (cres.done) state_next = S_MUL;
      S_MUL:    state_next = S_SUM;
      S_SUM:    state_next = S_OUT;
      S_OUT:    if (out_free) state_next = S_IDLE;
      default:  state_next = S_IDLE;
    endcase
  end

  // outputs and mode update
  logic [15:0]        babs;
  logic [16:0]        eabs;
  logic signed [36:0] lin;
  logic signed [31:0] lin_o;
  logic signed [15:0] ang_o;

  always_comb begin
    s_tready  = (state == S_IDLE);
    cstart    = (state == S_BSTART) || (state == S_DSTART);
    babs      = bearing[15] ? 16'(-bearing) : 16'(bearing);
    eabs      = e[16] ? 17'(-e) : 17'(e);
    mode_next = mode;
    wc_next   = wc;
    lin       = '0;
    ang_o     = '0;
    unique case (mode)
      MODE_DRIVE: begin
        lin   = (babs > {2'b0, turn_angle}) ? 37'sd0 : gdist;
        ang_o = sat_ang(24'(ang_d), max_ang);
        if (gdist < $signed({6'b0, goal_radius})) begin
          mode_next = MODE_WAIT;
          wc_next   = '0;
        end
      end
      MODE_WAIT: begin
        if (wc >= wait_ticks) mode_next = MODE_ALIGN;
        else wc_next = wc + 16'd1;
      end
      MODE_ALIGN: begin
        if (eabs > {3'b0, align_tol}) ang_o = sat_ang(24'(ang_a), max_ang);
        else mode_next = MODE_DONE;
      end
      MODE_DONE: ;
      default: ;
    endcase
    // distance is never negative, only the upper clamp can bite
    lin_o = (lin > $signed({6'b0, max_lin})) ? $signed({1'b0, max_lin}) : lin[31:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      mode        <= MODE_DRIVE;
      wc          <= '0;
      path_loaded <= 1'b0;
      m_tvalid    <= 1'b0;
    end else begin
      state <= state_next;
      if (accept && s_tuser) begin
        path_loaded <= 1'b1;
        if (mode == MODE_DONE) mode <= MODE_DRIVE;
      end
      if (out_load) begin
        mode     <= mode_next;
        wc       <= wc_next;
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) m_tdata <= {6'b0, mode_next, ang_o, lin_o};
  end

`include "goal_reach_heading_controller_macros.svh"

  `GRHC_ASSERT_NEXT(a_tick_starts, tick_go, state == S_BSTART, "tick did not start work")
  `GRHC_ASSERT_NOW(a_idle_cordic, state == S_IDLE, !cres.busy, "CORDIC busy while idle")
  `GRHC_ASSERT_NOW(a_valid_src, $rose(m_tvalid), $past(state) == S_OUT, "result out of sequence")

endmodule
`default_nettype wire

// File: tb/grhc_checker.sv
// ----------------------------------------------------------------------------
// grhc_checker
// Watches the config port and both streams of the heading controller. It
// keeps its own copy of the mode machine, predicts each command beat and
// compares the beats that come out against the predictions, oldest first.
// ----------------------------------------------------------------------------
`default_nettype none
module grhc_checker (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         cfg_we,
  input  wire logic [2:0]   cfg_index,
  input  wire logic [30:0]  cfg_data,
  input  wire logic         s_tvalid,
  input  wire logic         s_tready,
  input  wire logic [223:0] s_tdata,
  input  wire logic         s_tuser,
  input  wire logic         m_tvalid,
  input  wire logic         m_tready,
  input  wire logic [55:0]  m_tdata,
  output int                errors,
  output int                pending
);
  import grhc_pkg::*;

  typedef struct packed {
    mode_t       mode;
    logic [15:0] angular;
    logic [31:0] linear;
  } cmd_t;

  localparam longint ATAN_Q20 [16] = '{823550, 486170, 256879, 130396, 65451,
    32757, 16383, 8192, 4096, 2048, 1024, 512, 256, 128, 64, 32};

  longint max_lin, max_ang, head_gain, int_gain, radius, turn_ang, tol, wait_lim;
  mode_t  cur_mode;
  longint wait_cnt;
  logic   have_path;
  cmd_t   cmd_q[$];

  function automatic longint clamp_sym(input longint v, input longint lim);
    if (v > lim) return lim;
    if (v < -lim) return -lim;
    return v;
  endfunction

  // 16-step vectoring rotation; floor shifts via >>> on 64-bit signed values
  function automatic void vec_rotate(input longint x0, input longint y0,
                                     output longint mag, output longint ang);
    longint x, y, z, xs, ys;
    x = x0; y = y0; z = 0;
    for (int i = 0; i < 16; i++) begin
      xs = x >>> i;
      ys = y >>> i;
      if (y > 0) begin
        x = x + ys; y = y - xs; z = z + ATAN_Q20[i];
      end else begin
        x = x - ys; y = y + xs; z = z - ATAN_Q20[i];
      end
    end
    mag = x;
    ang = z;
  endfunction

  function automatic longint target_bearing(input longint dx, input longint dy);
    longint m, z;
    if (dx == 0 && dy == 0) return 0;
    if (dx >= 0) vec_rotate(dx, dy, m, z);
    else begin
      vec_rotate(-dx, -dy, m, z);
      z = z + ((dy >= 0) ? longint'(PI_Q20) : -longint'(PI_Q20));
    end
    return (z + 128) >>> 8;
  endfunction

  function automatic longint goal_distance(input longint dx, input longint dy);
    longint m, z;
    vec_rotate(dx < 0 ? -dx : dx, dy < 0 ? -dy : dy, m, z);
    return (m * longint'(INV_GAIN_Q16) + 32768) >>> 16;
  endfunction

  // one control tick: advances the mode machine and returns the command beat
  function automatic cmd_t control_tick(input logic [223:0] d);
    longint tdx, tdy, rx, ry, ryaw, gx, gy, gyaw;
    longint brg, babs, gdist, lin, ang, e, integ;
    cmd_t   c;
    tdx  = longint'($signed(d[31:0]));
    tdy  = longint'($signed(d[63:32]));
    rx   = longint'($signed(d[95:64]));
    ry   = longint'($signed(d[127:96]));
    ryaw = longint'($signed(d[142:128]));
    gx   = longint'($signed(d[174:143]));
    gy   = longint'($signed(d[206:175]));
    gyaw = longint'($signed(d[221:207]));
    brg  = target_bearing(tdx, tdy);
    babs = brg < 0 ? -brg : brg;
    gdist = goal_distance(gx - rx, gy - ry);
    lin  = 0;
    ang  = 0;
    case (cur_mode)
      MODE_DRIVE: begin
        lin = gdist;
        ang = clamp_sym((brg * head_gain + 2048) >>> 12, max_ang);
        if (babs > turn_ang) lin = 0;
        if (gdist < radius) begin
          cur_mode = MODE_WAIT;
          wait_cnt = 0;
        end
      end
      MODE_WAIT: begin
        if (wait_cnt >= wait_lim) cur_mode = MODE_ALIGN;
        else wait_cnt = (wait_cnt + 1) & 16'hFFFF;
      end
      MODE_ALIGN: begin
        // one 2*pi step of wrap only, even for out-of-range yaw
        e = gyaw - ryaw;
        if (e > longint'(PI_Q12)) e = e - longint'(TWO_PI_Q12);
        else if (e < -longint'(PI_Q12)) e = e + longint'(TWO_PI_Q12);
        integ = clamp_sym(e, longint'(I_LIMIT_Q12));
        if ((e < 0 ? -e : e) > tol)
          ang = clamp_sym((e * head_gain + integ * int_gain + 2048) >>> 12, max_ang);
        else cur_mode = MODE_DONE;
      end
      default: ;
    endcase
    lin       = clamp_sym(lin, max_lin);
    ang       = clamp_sym(ang, max_ang);
    c.linear  = lin[31:0];
    c.angular = ang[15:0];
    c.mode    = cur_mode;
    return c;
  endfunction

  always @(posedge clk) begin
    cmd_t got, want;
    if (rst) begin
      max_lin = 9830; max_ang = 4915; head_gain = 6144; int_gain = 4096;
      radius = 9830; turn_ang = 1024; tol = 205; wait_lim = 20;
      cur_mode = MODE_DRIVE;
      wait_cnt = 0;
      have_path = 1'b0;
      cmd_q.delete();
      errors = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_idx_t'(cfg_index))
          CFG_MAX_LIN:     max_lin   = cfg_data;
          CFG_MAX_ANG:     max_ang   = cfg_data[14:0];
          CFG_HEAD_GAIN:   head_gain = cfg_data[14:0];
          CFG_INT_GAIN:    int_gain  = cfg_data[14:0];
          CFG_GOAL_RADIUS: radius    = cfg_data;
          CFG_TURN_ANGLE:  turn_ang  = cfg_data[13:0];
          CFG_ALIGN_TOL:   tol       = cfg_data[13:0];
          CFG_WAIT_TICKS:  wait_lim  = cfg_data[15:0];
          default: ;
        endcase
      end
      if (m_tvalid && m_tready) begin
        got = m_tdata[49:0];
        if (cmd_q.size() == 0) begin
          errors++;
          if (errors <= 10) $display("unexpected command beat %h", m_tdata);
        end else begin
          want = cmd_q.pop_front();
          if (got.linear !== want.linear || got.angular !== want.angular ||
              got.mode !== want.mode) begin
            errors++;
            if (errors <= 10)
              $display("cmd mismatch: lin %0d/%0d ang %0d/%0d mode %0d/%0d (exp/act)",
                       $signed(want.linear), $signed(got.linear),
                       $signed(want.angular), $signed(got.angular),
                       want.mode, got.mode);
          end
        end
      end
      if (s_tvalid && s_tready) begin
        if (s_tuser) begin
          have_path = 1'b1;
          if (cur_mode == MODE_DONE) cur_mode = MODE_DRIVE;
        end else if (have_path) begin
          cmd_q.push_back(control_tick(s_tdata));
        end
      end
    end
    pending = cmd_q.size();
  end

endmodule
`default_nettype wire

// File: tb/goal_reach_heading_controller_test.sv
// ----------------------------------------------------------------------------
// goal_reach_heading_controller_test
// Drives path and tick beats through several register settings and lets the
// checker predict and compare every command beat.
// ----------------------------------------------------------------------------
`default_nettype none
module goal_reach_heading_controller_test;
  import grhc_pkg::*;

  localparam int LIMIT_CYCLES = 400000;
  localparam int HOLD_CYCLES  = 1500;

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         cfg_we = 1'b0;
  logic [2:0]   cfg_index = '0;
  logic [30:0]  cfg_data = '0;
  logic         s_tvalid = 1'b0;
  logic         s_tready;
  // target_dx, target_dy, robot_x, robot_y, robot_heading, goal_x, goal_y,
  // goal_heading
  logic [223:0] s_tdata = '0;
  // kind
  logic         s_tuser = 1'b0;
  logic         m_tvalid;
  logic         m_tready = 1'b0;
  // linear_cmd, angular_cmd, mode
  logic [55:0]  m_tdata;

  int     errors, pending;
  int     cycles = 0;
  logic   quiet = 1'b0;      // no idling at all in the last part
  logic   tx_calm = 1'b0;    // sender stretch with no gaps
  logic   hold_req = 1'b0;   // asks the receiver for one long hold-off
  logic   hold_done = 1'b0;
  int     hold_cnt = 0;
  int     stall_left = 0;
  longint cfg_val [8];

  goal_reach_heading_controller u_top (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata
  );

  grhc_checker u_checker (
    .clk, .rst, .cfg_we, .cfg_index, .cfg_data,
    .s_tvalid, .s_tready, .s_tdata, .s_tuser,
    .m_tvalid, .m_tready, .m_tdata,
    .errors, .pending
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles >= LIMIT_CYCLES) begin
      $display("RESULT: ERROR");
      $finish;
    end
  end

  // receiver: random stall bursts, calm stretches, one long hold-off on request
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
    end else if (hold_req && !hold_done) begin
      m_tready <= 1'b0;
      hold_cnt <= hold_cnt + 1;
      if (hold_cnt >= HOLD_CYCLES) hold_done <= 1'b1;
    end else if (stall_left > 0) begin
      m_tready <= 1'b0;
      stall_left <= stall_left - 1;
    end else if (!quiet && cycles[11] && $urandom_range(0, 5) == 0) begin
      m_tready <= 1'b0;
      stall_left <= $urandom_range(0, 8);
    end else begin
      m_tready <= 1'b1;
    end
  end

  function automatic logic [223:0] pack_tick(
      input longint tdx, input longint tdy, input longint rx, input longint ry,
      input longint ryaw, input longint gx, input longint gy, input longint gyaw);
    logic [223:0] d;
    d = '0;
    d[31:0]    = tdx[31:0];
    d[63:32]   = tdy[31:0];
    d[95:64]   = rx[31:0];
    d[127:96]  = ry[31:0];
    d[142:128] = ryaw[14:0];
    d[174:143] = gx[31:0];
    d[206:175] = gy[31:0];
    d[221:207] = gyaw[14:0];
    return d;
  endfunction

  function automatic longint rnd_pos();
    case ($urandom_range(0, 3))
      0: return longint'($signed($urandom()));
      1: return longint'($urandom_range(0, 32'h3FFFF)) - 32'h1FFFF;
      2: case ($urandom_range(0, 3))
           0: return -64'sd2147483648;
           1: return 64'sd2147483647;
           2: return 0;
           default: return -1;
         endcase
      default: return longint'($urandom_range(0, 32'hFFFFFF)) - 32'h7FFFFF;
    endcase
  endfunction

  function automatic longint rnd_yaw();
    if ($urandom_range(0, 9) == 0) return longint'($urandom_range(0, 32767)) - 16384;
    return longint'($urandom_range(0, 25736)) - 12868;
  endfunction

  // offset with magnitude up to lim on one axis, random sign
  function automatic longint rnd_off(input longint lim);
    longint v;
    v = (lim > 0) ? longint'($urandom_range(0, (lim > 32'h7FFFFFFF) ? 32'h7FFFFFFF : lim)) : 0;
    return $urandom_range(0, 1) ? -v : v;
  endfunction

  // one beat; the valid stays up into the next call unless a gap follows
  task automatic send_beat(input logic kind, input logic [223:0] d);
    s_tvalid <= 1'b1;
    s_tuser  <= kind;
    s_tdata  <= d;
    do @(posedge clk); while (!s_tready);
    if (!quiet && !tx_calm && $urandom_range(0, 3) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
  endtask

  task automatic new_path();
    send_beat(1'b1, pack_tick(rnd_pos(), rnd_pos(), rnd_pos(), rnd_pos(), rnd_yaw(),
                              rnd_pos(), rnd_pos(), rnd_yaw()));
  endtask

  // tick with the goal either well inside the goal radius or offset by up to 0x3FFFFF per axis
  task automatic drive_tick(input logic near_goal);
    longint rx, ry, lim;
    rx = longint'($urandom_range(0, 32'hFFFFFF)) - 32'h7FFFFF;
    ry = longint'($urandom_range(0, 32'hFFFFFF)) - 32'h7FFFFF;
    lim = near_goal ? cfg_val[CFG_GOAL_RADIUS] / 3 : 32'h3FFFFF;
    send_beat(1'b0, pack_tick(rnd_pos(), rnd_pos(), rx, ry, rnd_yaw(),
                              rx + rnd_off(lim), ry + rnd_off(lim), rnd_yaw()));
  endtask

  // tick with a chosen yaw error, goal yaw wrapped back into range
  task automatic yaw_tick(input longint err);
    longint ryaw, gyaw;
    ryaw = longint'($urandom_range(0, 25736)) - 12868;
    gyaw = ryaw + err;
    if (gyaw > 12868) gyaw = gyaw - 25736;
    else if (gyaw < -12868) gyaw = gyaw + 25736;
    send_beat(1'b0, pack_tick(rnd_pos(), rnd_pos(), rnd_pos(), rnd_pos(), ryaw,
                              rnd_pos(), rnd_pos(), gyaw));
  endtask

  // drive, stop-wait, align and done sequence, random content; align and done are reached only for a wait limit below 8
  task automatic reach_goal();
    longint tol, err;
    repeat ($urandom_range(1, 5)) drive_tick(1'b0);
    drive_tick(1'b1);
    repeat ((cfg_val[CFG_WAIT_TICKS] < 8) ? cfg_val[CFG_WAIT_TICKS] + 1 : 3)
      drive_tick($urandom_range(0, 1));
    tol = cfg_val[CFG_ALIGN_TOL];
    repeat ($urandom_range(0, 4)) begin
      err = tol + 1 + $urandom_range(0, 3000);
      yaw_tick($urandom_range(0, 1) ? -err : err);
    end
    err = $urandom_range(0, tol);
    yaw_tick($urandom_range(0, 1) ? -err : err);
    repeat ($urandom_range(0, 2)) drive_tick(1'b0);
  endtask

  // the extra edge lets the checker count the last accepted beat
  task automatic settle();
    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (80) @(posedge clk);
  endtask

  task automatic write_regs(input longint v [8]);
    for (int i = 0; i < 8; i++) begin
      cfg_val[i] = v[i];
      cfg_we    <= 1'b1;
      cfg_index <= cfg_idx_t'(i);
      cfg_data  <= v[i][30:0];
      @(posedge clk);
    end
    cfg_we <= 1'b0;
  endtask

  initial begin
    longint v [8];
    cfg_val = '{9830, 4915, 6144, 4096, 9830, 1024, 205, 20};
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed: ticks before any path, then corner vectors and extremes
    send_beat(1'b0, pack_tick(5, 5, 0, 0, 0, 0, 0, 0));
    send_beat(1'b0, '1);
    new_path();
    send_beat(1'b0, pack_tick(0, 0, 0, 0, 0, 65536 * 50, 0, 0));     // zero target
    send_beat(1'b0, pack_tick(-65536, 0, 0, 0, 0, 0, 65536 * 50, 0)); // bearing pi
    send_beat(1'b0, pack_tick(-65536, -1, 0, 0, 0, 0, 65536 * 50, 0));
    send_beat(1'b0, pack_tick(-2147483648, -2147483648, 2147483647, 2147483647,
                              -16384, -2147483648, -2147483648, 16383));
    send_beat(1'b0, pack_tick(2147483647, 2147483647, -2147483648, -2147483648,
                              16383, 2147483647, 2147483647, -16384));
    send_beat(1'b0, pack_tick(65536, 0, 0, 0, 0, 0, 0, 0));           // at goal
    repeat (21) drive_tick(1'b0);                                     // stop-wait
    send_beat(1'b0, pack_tick(0, 0, 0, 0, -16384, 0, 0, 16383));      // out-of-range yaw
    yaw_tick(100);
    drive_tick(1'b0);                                                 // done
    new_path();
    new_path();
    settle();

    for (int ph = 0; ph < 6; ph++) begin
      case (ph)
        0: v = '{9830, 4915, 6144, 4096, 9830, 1024, 205, 3};
        1: v = '{2147483647, 32767, 32767, 32767, 2147483647, 12868, 12868, 0};
        2: v = '{0, 0, 0, 0, 0, 0, 0, 65535};
        default: v = '{$urandom_range(0, 32'h7FFFFFFF), $urandom_range(0, 32767),
                       $urandom_range(0, 32767), $urandom_range(0, 32767),
                       $urandom_range(0, 32'h7FFFF), $urandom_range(0, 12868),
                       $urandom_range(0, 12868), $urandom_range(0, 6)};
      endcase
      write_regs(v);
      if (ph == 5) quiet <= 1'b1;
      for (int n = 0; n < 11; n++) begin
        tx_calm <= (n == 3);
        new_path();
        if (ph == 1 && n == 2) begin
          // long receiver hold-off while ticks keep coming
          hold_req <= 1'b1;
          repeat (12) drive_tick(1'b0);
        end
        if ($urandom_range(0, 4) == 0)
          repeat ($urandom_range(1, 6))
            send_beat($urandom_range(0, 7) == 0,
                      pack_tick(rnd_pos(), rnd_pos(), rnd_pos(), rnd_pos(), rnd_yaw(),
                                rnd_pos(), rnd_pos(), rnd_yaw()));
        else reach_goal();
        if (n == 5) begin
          s_tvalid <= 1'b0;
          @(posedge clk);
          wait (pending == 0);
          @(posedge clk);
        end
      end
      settle();
    end

    s_tvalid <= 1'b0;
    @(posedge clk);
    wait (pending == 0);
    repeat (100) @(posedge clk);
    if (errors == 0) $display("RESULT: OK");
    else $display("RESULT: ERROR");
    $finish;
  end

endmodule
`default_nettype wire

// File: goal_reach_heading_controller.f
+incdir+hw/rtl
hw/rtl/grhc_pkg.sv
hw/rtl/grhc_cordic.sv
hw/rtl/goal_reach_heading_controller.sv
tb/grhc_checker.sv
tb/goal_reach_heading_controller_test.sv
